// File: hw/rtl/led_status_pattern_sequencer_macros.svh
// Assertion macros used by the LED status pattern sequencer top level.
`ifndef LED_STATUS_PATTERN_SEQUENCER_MACROS_SVH
`define LED_STATUS_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define LSPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lsps assertion failed");

// The condition must never be true outside reset.
`define LSPS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lsps forbidden condition seen");

`else

`define LSPS_ASSERT(label, clk, rst_n, prop)
`define LSPS_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/lsps_pkg.sv
// Types, constants and the blink pattern ROM of the LED status pattern sequencer.
`timescale 1ns / 1ps

package lsps_pkg;

  localparam int unsigned PATTERN_COUNT     = 5;
  localparam int unsigned ROM_WIDTH         = 16;
  localparam int unsigned ROM_STEP_W        = 6;
  localparam int unsigned MAX_PATTERN_STEPS = 16;
  localparam logic [7:0]  TICKS_RESET       = 8'd10;

  typedef enum logic {
    CMD_TICK       = 1'b0,
    CMD_SET_STATUS = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [2:0] status;
  } in_t;

  typedef struct packed {
    logic led_on;
    logic toggled;
  } out_t;

  typedef struct packed {
    logic [2:0]  last_status;
    logic [2:0]  active_pattern;
    logic [15:0] countdown;
    logic        led_level;
  } state_t;

  // Step durations in units; a zero ends the pattern.
  localparam logic [7:0] PATTERN_ROM [PATTERN_COUNT][ROM_WIDTH] = '{
    '{8'd150, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 8'd2, 8'd20, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd10, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd20, 8'd2, 8'd20, 8'd2, 8'd20, 8'd2, 8'd20, 8'd100,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd10, 8'd2, 8'd10, 8'd2, 8'd10, 8'd2, 8'd10, 8'd2,
      8'd30, 8'd2, 8'd30, 8'd2, 8'd30, 8'd2, 8'd20, 8'd0}
  };

  // Steps past the stored pattern and unknown patterns read as zero.
  function automatic logic [7:0] rom_read(logic [2:0] pat, logic [ROM_STEP_W-1:0] step);
    logic [7:0] dur;
    dur = 8'd0;
    if ((pat < 3'(PATTERN_COUNT)) && (step < ROM_STEP_W'(ROM_WIDTH))) begin
      dur = PATTERN_ROM[pat][step[3:0]];
    end
    return dur;
  endfunction

endpackage

// File: hw/rtl/led_status_pattern_sequencer.sv
// Top level of the LED status pattern sequencer: input, state and result registers.
// Beats pass from the input register to the result register. Throughput: one beat
// per cycle unless stalled; the single pass from the input register through the ROM
// lookup and the 8x8 scale multiply to the result register sets this.
// Reset (rst_ni low, asynchronous): LED off, single blink pattern at step 0,
// countdown expired, last status idle write, ticks_per_unit 10, both stages empty.
`timescale 1ns / 1ps
`include "led_status_pattern_sequencer_macros.svh"

module led_status_pattern_sequencer #(
  parameter int unsigned MAX_PATTERN_STEPS = lsps_pkg::MAX_PATTERN_STEPS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsps_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lsps_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i
);
  import lsps_pkg::*;

  localparam int unsigned STEP_W = $clog2(MAX_PATTERN_STEPS);

  logic              in_valid_q, in_valid_d;
  in_t               in_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;
  state_t            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [7:0]        tpu_q;
  out_t              result;
  logic              advance;
  logic              proc;
  logic              in_accept;

  // The result stage can take a beat when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  lsps_step #(
    .MAX_PATTERN_STEPS(MAX_PATTERN_STEPS)
  ) u_step (
    .state_i          (state_q),
    .step_i           (step_q),
    .item_i           (in_q),
    .ticks_per_unit_i (tpu_q),
    .state_o          (state_d),
    .step_o           (step_d),
    .result_o         (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      step_q      <= '0;
      tpu_q       <= TICKS_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        state_q <= state_d;
        step_q  <= step_d;
      end
      if (cfg_we_i) begin
        tpu_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_i;
    end
    if (proc) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LSPS_ASSERT(a_set_never_toggles, clk_i, rst_ni,
    (proc && in_q.command == CMD_SET_STATUS) |=> !out_q.toggled)
  `LSPS_ASSERT(a_new_status_restarts, clk_i, rst_ni,
    (proc && in_q.command == CMD_SET_STATUS && in_q.status != state_q.last_status)
      |=> (step_q == '0 && state_q.countdown == 16'd0))
  `LSPS_ASSERT(a_proc_fills_result, clk_i, rst_ni, proc |=> out_valid_q)
  `LSPS_ASSERT_NEVER(a_step_in_range, clk_i, rst_ni,
    {1'b0, step_q} >= (STEP_W+1)'(MAX_PATTERN_STEPS))

endmodule

// File: hw/rtl/lsps_step.sv
// Next-state and result logic for one tick or set-status beat.
`timescale 1ns / 1ps

module lsps_step #(
  parameter int unsigned MAX_PATTERN_STEPS = lsps_pkg::MAX_PATTERN_STEPS,
  localparam int unsigned STEP_W = $clog2(MAX_PATTERN_STEPS)
) (
  input  lsps_pkg::state_t  state_i,
  input  logic [STEP_W-1:0] step_i,
  input  lsps_pkg::in_t     item_i,
  input  logic [7:0]        ticks_per_unit_i,
  output lsps_pkg::state_t  state_o,
  output logic [STEP_W-1:0] step_o,
  output lsps_pkg::out_t    result_o
);
  import lsps_pkg::*;

  logic [15:0]     cd_dec;
  logic            fire;
  logic [7:0]      dur;
  logic [STEP_W:0] next_step;
  logic            wrap;

  assign cd_dec    = (state_i.countdown != 16'd0) ? state_i.countdown - 16'd1 : 16'd0;
  assign fire      = (item_i.command == CMD_TICK) && (cd_dec == 16'd0);
  assign dur       = rom_read(state_i.active_pattern, ROM_STEP_W'(step_i));
  assign next_step = {1'b0, step_i} + (STEP_W+1)'(1);
  // A next step past the bound would also read zero, so the ROM test is safe to truncate.
  assign wrap      = (next_step >= (STEP_W+1)'(MAX_PATTERN_STEPS))
                  || (rom_read(state_i.active_pattern, ROM_STEP_W'(next_step)) == 8'd0);

  always_comb begin
    state_o = state_i;
    step_o  = step_i;
    if (item_i.command == CMD_SET_STATUS) begin
      if (item_i.status != state_i.last_status) begin
        if (item_i.status < 3'(PATTERN_COUNT)) begin
          state_o.active_pattern = item_i.status;
        end
        state_o.last_status = item_i.status;
        state_o.countdown   = 16'd0;
        step_o              = '0;
      end
    end else begin
      state_o.countdown = cd_dec;
      if (fire) begin
        state_o.countdown = 16'(dur) * 16'(ticks_per_unit_i);
        state_o.led_level = step_i[0];
        step_o            = wrap ? '0 : next_step[STEP_W-1:0];
      end
    end
  end

  assign result_o.led_on  = state_o.led_level;
  assign result_o.toggled = fire;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LED status pattern sequencer.
`timescale 1ns / 1ps

module testbench;
  import lsps_pkg::*;

  localparam int unsigned STEP_LIMIT   = 16;
  localparam int unsigned NUM_PATTERNS = 5;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned RANDOM_PHASES = 8;

  // Step durations in units for each blink pattern; a zero ends the pattern.
  localparam logic [7:0] BLINK_DURATIONS [NUM_PATTERNS][16] = '{
    '{8'd150, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd100, 8'd2, 8'd20, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd10, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd20, 8'd2, 8'd20, 8'd2, 8'd20, 8'd2, 8'd20, 8'd100,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd10, 8'd2, 8'd10, 8'd2, 8'd10, 8'd2, 8'd10, 8'd2,
      8'd30, 8'd2, 8'd30, 8'd2, 8'd30, 8'd2, 8'd20, 8'd0}
  };

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_SPARSE,
    SINK_PERIODIC,
    SINK_COIN
  } sink_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_t        in_i        = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  // Predicted state of the sequencer.
  logic [7:0]  seq_ticks       = 8'd10;
  logic [2:0]  seq_last_status = 3'd0;
  logic [2:0]  seq_pattern     = 3'd0;
  int unsigned seq_step        = 0;
  logic [15:0] seq_countdown   = 16'd0;
  logic        seq_led         = 1'b0;

  out_t        led_expected[$];
  int unsigned err_count  = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  sink_mode_e  sink_mode  = SINK_OPEN;
  int unsigned sink_left  = 0;
  int unsigned sink_phase = 0;

  led_status_pattern_sequencer #(
    .MAX_PATTERN_STEPS(STEP_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] step_duration(logic [2:0] pat, int unsigned step);
    logic [7:0] dur;
    dur = 8'd0;
    if (pat < 3'(NUM_PATTERNS) && step < 16) begin
      dur = BLINK_DURATIONS[pat][step];
    end
    return dur;
  endfunction

  // Advances the predicted state by one beat and returns the LED result it causes.
  function automatic out_t predict_led(in_t it);
    out_t        res;
    int unsigned nxt;
    res.toggled = 1'b0;
    if (it.command == CMD_SET_STATUS) begin
      if (it.status != seq_last_status) begin
        // A status without a pattern still restarts the current one.
        if (it.status < 3'(NUM_PATTERNS)) begin
          seq_pattern = it.status;
        end
        seq_step        = 0;
        seq_countdown   = 16'd0;
        seq_last_status = it.status;
      end
    end else begin
      if (seq_countdown != 16'd0) begin
        seq_countdown = seq_countdown - 16'd1;
      end
      if (seq_countdown == 16'd0) begin
        seq_countdown = 16'(step_duration(seq_pattern, seq_step)) * 16'(seq_ticks);
        seq_led       = seq_step[0];
        nxt           = seq_step + 1;
        if (nxt >= STEP_LIMIT || step_duration(seq_pattern, nxt) == 8'd0) begin
          nxt = 0;
        end
        seq_step    = nxt;
        res.toggled = 1'b1;
      end
    end
    res.led_on = seq_led;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Sends one beat; the sender idles between bursts of random length.
  task automatic send_item(input cmd_e cmd, input logic [2:0] status);
    in_t         it;
    int unsigned gap;
    it.command = cmd;
    it.status  = status;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        burst_left = $urandom_range(1, 20);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    led_expected.push_back(predict_led(it));
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 3'($urandom_range(0, 7)));
  endtask

  task automatic set_status(input logic [2:0] status);
    send_item(CMD_SET_STATUS, status);
  endtask

  // Writes ticks_per_unit once every outstanding result has drained.
  task automatic write_ticks(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (led_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    seq_ticks = value;
  endtask

  task automatic test_after_reset();
    // The countdown comes out of reset expired, so the first tick fires.
    repeat (3) send_tick();
  endtask

  task automatic test_status_select();
    set_status(3'd3);
    send_tick();
    set_status(3'd3);
    send_tick();
    set_status(3'd5);
    send_tick();
    set_status(3'd7);
    set_status(3'd0);
    send_tick();
    set_status(3'd2);
    send_tick();
  endtask

  task automatic test_zero_scale();
    write_ticks(8'd0);
    // Every tick fires, so this walks the longest pattern and wraps it.
    set_status(3'd4);
    repeat (17) send_tick();
  endtask

  task automatic test_random_traffic();
    logic [7:0]  scale_plan [RANDOM_PHASES];
    int unsigned set_pct;
    logic [2:0]  st;
    scale_plan = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd1, 8'd3, 8'd10, 8'd5};
    scale_plan[6] = 8'($urandom_range(1, 255));
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_ticks(scale_plan[ph]);
      set_pct = $urandom_range(1, 15);
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
        if ($urandom_range(0, 99) < set_pct) begin
          if ($urandom_range(0, 9) == 0) begin
            st = 3'($urandom_range(5, 7));
          end else if ($urandom_range(0, 9) == 0) begin
            st = seq_last_status;
          end else begin
            st = 3'($urandom_range(0, 4));
          end
          set_status(st);
        end else begin
          send_tick();
        end
      end
    end
  endtask

  // The receiver switches among stall patterns, one of them never stalling.
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(32, 256);
    end
    sink_left--;
    sink_phase++;
    case (sink_mode)
      SINK_OPEN: begin
        out_ready_i <= 1'b1;
      end
      SINK_SPARSE: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      SINK_PERIODIC: begin
        out_ready_i <= ((sink_phase % 7) >= 3);
      end
      default: begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (led_expected.size() == 0) begin
        report_mismatch("result beat with no result expected");
      end else begin
        want = led_expected.pop_front();
        if (out_o.led_on !== want.led_on) begin
          report_mismatch($sformatf("led_on %b, expected %b", out_o.led_on, want.led_on));
        end
        if (out_o.toggled !== want.toggled) begin
          report_mismatch($sformatf("toggled %b, expected %b", out_o.toggled, want.toggled));
        end
      end
    end
  end

  // Counts cycles with work pending but no beat moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (in_valid_i || led_expected.size() != 0) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_status_select();
    test_zero_scale();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (led_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_step.sv
hw/rtl/led_status_pattern_sequencer.sv
tb/testbench.sv
